[hw/rtl/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on clk_i, off while rst_ni is low
`define ACFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold out of reset
`define ACFT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[hw/rtl/acft_pkg.sv]
// types, opcodes, flag update and status functions for the assertion control flag table
`default_nettype none

package acft_pkg;

  localparam int IdxW             = 6;
  localparam int NumIdx           = 2 ** IdxW;
  localparam int DefaultInstances = 64;
  localparam int OpW              = 4;
  localparam int InDataW          = 16;
  localparam int OutDataW         = 8;

  typedef enum logic [OpW-1:0] {
    OP_LOCK          = 4'd0,
    OP_UNLOCK        = 4'd1,
    OP_ON            = 4'd2,
    OP_OFF           = 4'd3,
    OP_KILL          = 4'd4,
    OP_PASS_ON       = 4'd5,
    OP_PASS_OFF      = 4'd6,
    OP_FAIL_ON       = 4'd7,
    OP_FAIL_OFF      = 4'd8,
    OP_NONVACUOUS_ON = 4'd9,
    OP_VACUOUS_OFF   = 4'd10,
    OP_GLOBAL_OFF    = 4'd11,
    OP_GLOBAL_ON     = 4'd12
  } op_e;

  // disabled sits in bit 0
  typedef struct packed {
    logic fail_off;
    logic nvac_off;
    logic vac_off;
    logic locked;
    logic killed;
    logic disabled;
  } flags_t;

  // enabled sits in bit 0
  typedef struct packed {
    logic global_disabled;
    logic fail_enabled;
    logic pass_enabled;
    logic nonvacuous_pass_enabled;
    logic vacuous_pass_enabled;
    logic locked;
    logic killed;
    logic enabled;
  } status_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    flags_t          data;
  } wr_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
  } rd_t;

  function automatic flags_t next_flags(logic [OpW-1:0] op, flags_t f);
    flags_t n;
    n = f;
    if (op == OP_UNLOCK) begin
      n.locked = 1'b0;
    end else if (!f.locked) begin
      case (op)
        OP_LOCK:          n.locked   = 1'b1;
        OP_ON:            n.disabled = 1'b0;
        OP_OFF:           n.disabled = 1'b1;
        OP_KILL: begin
          n.killed   = 1'b1;
          n.disabled = 1'b1;
        end
        OP_PASS_ON: begin
          n.vac_off  = 1'b0;
          n.nvac_off = 1'b0;
        end
        OP_PASS_OFF: begin
          n.vac_off  = 1'b1;
          n.nvac_off = 1'b1;
        end
        OP_FAIL_ON:       n.fail_off = 1'b0;
        OP_FAIL_OFF:      n.fail_off = 1'b1;
        OP_NONVACUOUS_ON: n.nvac_off = 1'b0;
        OP_VACUOUS_OFF:   n.vac_off  = 1'b1;
        default:          n = f;
      endcase
    end
    return n;
  endfunction

  function automatic status_t make_status(flags_t f, logic gdis);
    status_t s;
    s.enabled                 = !gdis && !f.disabled && !f.killed;
    s.killed                  = f.killed;
    s.locked                  = f.locked;
    s.vacuous_pass_enabled    = !f.vac_off;
    s.nonvacuous_pass_enabled = !f.nvac_off;
    s.pass_enabled            = !f.vac_off && !f.nvac_off;
    s.fail_enabled            = !f.fail_off;
    s.global_disabled         = gdis;
    return s;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/acft_flag_mem.sv]
// flag memory with per-entry valid bits and registered read
`default_nettype none

module acft_flag_mem #(
  parameter int DEPTH = acft_pkg::DefaultInstances
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  acft_pkg::wr_t       wr_i,
  input  acft_pkg::rd_t       rd_i,
  output acft_pkg::flags_t    rd_flags_o
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  acft_pkg::flags_t mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  acft_pkg::flags_t rd_data_q;
  logic             rd_vld_q;

  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;

  assign waddr = wr_i.addr[AddrW-1:0];
  assign raddr = rd_i.addr[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[waddr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[waddr] <= 1'b1;
      end
      if (rd_i.en) begin
        rd_vld_q <= vld_q[raddr];
      end
    end
  end

  assign rd_flags_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

[hw/rtl/assertion_control_flag_table.sv]
// top level of the assertion control flag table
//
//   channel  dir  tdata fields (low bit up)
//   s_axis   in   opcode[3:0], instance_req[9:4], zero pad[15:10]
//   m_axis   out  enabled, killed, locked, vacuous_pass_enabled,
//                 nonvacuous_pass_enabled, pass_enabled, fail_enabled,
//                 global_disabled
//
// one transfer per cycle while the result is not stalled
// stage one holds the flag read, stage two the result register
// a write to the flag memory forwards to the next item on the same instance
// reset clears every entry at once through valid bits; no clearing pass
// a stalled result holds stage one, and input ready drops while stage one is held
`default_nettype none
`include "assert_macros.svh"

module assertion_control_flag_table #(
  parameter int INSTANCES = acft_pkg::DefaultInstances
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // opcode, instance_req, zero pad
  input  wire  [acft_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  // enabled, killed, locked, vacuous, nonvacuous, pass, fail, global_disabled
  output logic [acft_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  localparam int Depth = (INSTANCES < acft_pkg::NumIdx) ? INSTANCES : acft_pkg::NumIdx;

  logic                          in_acc;
  logic [acft_pkg::OpW-1:0]      in_op;
  logic [acft_pkg::IdxW-1:0]     in_idx;
  logic                          in_range;

  logic                          s1_vld_q;
  logic [acft_pkg::OpW-1:0]      s1_op_q;
  logic [acft_pkg::IdxW-1:0]     s1_idx_q;
  logic                          s1_range_q;
  logic                          byp_q;
  acft_pkg::flags_t              byp_flags_q;
  logic                          s1_adv;
  logic                          s1_we;
  acft_pkg::flags_t              rd_flags;
  acft_pkg::flags_t              s1_cur;
  acft_pkg::flags_t              s1_next;
  acft_pkg::flags_t              s1_res;
  logic                          gdis_d;
  logic                          global_off_q;
  acft_pkg::status_t             s1_status;

  logic                          out_vld_q;
  acft_pkg::status_t             out_data_q;

  acft_pkg::wr_t                 wr;
  acft_pkg::rd_t                 rd;

  assign in_op    = s_axis_tdata_i[acft_pkg::OpW-1:0];
  assign in_idx   = s_axis_tdata_i[acft_pkg::OpW +: acft_pkg::IdxW];
  assign in_range = 32'(in_idx) < INSTANCES;

  assign s1_adv          = s1_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_vld_q || s1_adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign rd.en   = in_acc && in_range;
  assign rd.addr = in_idx;

  acft_flag_mem #(
    .DEPTH (Depth)
  ) u_flag_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .rd_i       (rd),
    .rd_flags_o (rd_flags)
  );

  always_comb begin
    if (!s1_range_q) begin
      s1_cur = '0;
    end else if (byp_q) begin
      s1_cur = byp_flags_q;
    end else begin
      s1_cur = rd_flags;
    end
  end

  assign s1_next = acft_pkg::next_flags(s1_op_q, s1_cur);
  assign s1_we   = s1_range_q && (s1_op_q <= acft_pkg::OP_VACUOUS_OFF);

  // an instance out of range reports a cleared entry
  always_comb begin
    s1_res = s1_next;
    if (!s1_range_q) begin
      s1_res = '0;
    end
  end

  always_comb begin
    gdis_d = global_off_q;
    if (s1_op_q == acft_pkg::OP_GLOBAL_OFF) begin
      gdis_d = 1'b1;
    end else if (s1_op_q == acft_pkg::OP_GLOBAL_ON) begin
      gdis_d = 1'b0;
    end
  end

  assign s1_status = acft_pkg::make_status(s1_res, gdis_d);

  assign wr.en   = s1_adv && s1_we;
  assign wr.addr = s1_idx_q;
  assign wr.data = s1_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q     <= 1'b0;
      byp_q        <= 1'b0;
      global_off_q <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s1_vld_q <= s_axis_tvalid_i;
      end
      if (in_acc) begin
        byp_q <= wr.en && (s1_idx_q == in_idx);
      end
      if (s1_adv) begin
        global_off_q <= gdis_d;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q     <= in_op;
      s1_idx_q    <= in_idx;
      s1_range_q  <= in_range;
      byp_flags_q <= s1_next;
    end
    if (s1_adv) begin
      out_data_q <= s1_status;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  `ACFT_ASSERT(a_lock_holds,
               s1_vld_q && s1_cur.locked && (s1_op_q != acft_pkg::OP_UNLOCK)
                 |-> s1_next == s1_cur,
               "locked entry changed")
  `ACFT_ASSERT(a_stall_cause,
               !s_axis_tready_o |-> s1_vld_q && out_vld_q && !m_axis_tready_i,
               "input stalled without output stall")
  `ACFT_ASSERT(a_global_off,
               s1_adv && (s1_op_q == acft_pkg::OP_GLOBAL_OFF) |=> global_off_q,
               "global off not taken")
  `ACFT_ASSERT_NEVER(a_killed_enabled,
                     out_vld_q && out_data_q.killed && out_data_q.enabled,
                     "killed instance reported enabled")

endmodule

`default_nettype wire
